// ----- rtl/aesrk_pkg.sv -----
// Shared types, constants and byte-level functions for the rekeyed AES-128 pipeline.
// No dependencies; used by every module of the block.
package aesrk_pkg;

    localparam int Rounds = 10;

    typedef logic [127:0] blk_t;

    typedef logic [7:0] rcon_arr_t [Rounds];
    localparam rcon_arr_t RCON = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                   8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    typedef logic [7:0] sbox_arr_t [256];
    localparam sbox_arr_t SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Byte i of a block sits in bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input blk_t b, input int unsigned i);
        get_byte = b[127 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ----- rtl/aesrk_round.sv -----
// One cell of the chain: one AES round plus the matching key schedule step.
// Depends on aesrk_pkg.
module aesrk_round import aesrk_pkg::*; (
    input  logic       aclk,
    input  logic       en,
    input  logic [7:0] rcon,
    input  logic       final_round,
    input  blk_t       state_in,
    input  blk_t       key_in,
    input  logic       last_in,
    output blk_t       state_out,
    output blk_t       key_out,
    output logic       last_out
);

    blk_t state_reg, key_reg;
    logic last_reg;
    blk_t key_next, state_next;
    blk_t sr;

    // Next round key from the previous one.
    always_comb begin
        logic [31:0] w0, w1, w2, w3, t;
        w0 = key_in[127:96];
        w1 = key_in[95:64];
        w2 = key_in[63:32];
        w3 = key_in[31:0];
        t  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        key_next = {w0, w1, w2, w3};
    end

    // SubBytes and ShiftRows: out byte c*4+i from in byte ((c+i)&3)*4+i.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                sr[127 - 8 * (c * 4 + i) -: 8] =
                    SBOX[get_byte(state_in, ((c + i) % 4) * 4 + i)];
            end
        end
    end

    always_comb begin
        logic [7:0] a0, a1, a2, a3;
        blk_t mc;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(sr, c * 4);
            a1 = get_byte(sr, c * 4 + 1);
            a2 = get_byte(sr, c * 4 + 2);
            a3 = get_byte(sr, c * 4 + 3);
            mc[127 - 8 * (c * 4) -: 8]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            mc[127 - 8 * (c * 4 + 1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            mc[127 - 8 * (c * 4 + 2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            mc[127 - 8 * (c * 4 + 3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        state_next = (final_round ? sr : mc) ^ key_next;
    end

    // Hold while the pipeline is stalled.
    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
            key_reg   <= key_next;
            last_reg  <= last_in;
        end
    end

    assign state_out = state_reg;
    assign key_out   = key_reg;
    assign last_out  = last_reg;

endmodule

// ----- rtl/aes128_rekeyed_block_encrypt.sv -----
// Top level of the rekeyed AES-128 encryptor: input whitening stage and a chain of ten
// round cells with a valid bit per stage. Depends on aesrk_pkg and aesrk_round.
//
//  channel | direction | payload                                    | handshake
//  s_      | in        | key_high/low, plain_high/low, last_block   | s_valid / s_ready
//  m_      | out       | cipher_high/low, last_out                  | m_valid / m_ready
//
// A request passes the whitening register and then the ten round registers before m_valid
// rises for its result.
// Throughput: one request per cycle unless the output stalls; each round has its own cell, so nothing is shared.
// The whole chain advances together; a stalled output with a full final stage freezes it,
// and while frozen, bubbles in earlier stages are held rather than squeezed out.
// Reset (aresetn low, synchronous) clears only the stage valid bits.
module aes128_rekeyed_block_encrypt import aesrk_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_key_high,
    input  logic [63:0] s_key_low,
    input  logic [63:0] s_plain_high,
    input  logic [63:0] s_plain_low,
    input  logic        s_last_block,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_cipher_high,
    output logic [63:0] m_cipher_low,
    output logic        m_last_out
);

    localparam int Stages = Rounds + 1;

    logic [Stages-1:0] vld_reg, vld_next;
    logic              adv;
    blk_t              st_reg, key_reg;
    logic              last_reg;
    blk_t              st_c [Stages];
    blk_t              key_c [Stages];
    logic              last_c [Stages];

    // Advance whenever the final stage is empty or being drained.
    assign adv     = !vld_reg[Stages-1] || m_ready;
    assign s_ready = adv;

    // Stage 0: AddRoundKey with the raw key.
    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg   <= {s_plain_high, s_plain_low} ^ {s_key_high, s_key_low};
            key_reg  <= {s_key_high, s_key_low};
            last_reg <= s_last_block;
        end
    end

    assign st_c[0]   = st_reg;
    assign key_c[0]  = key_reg;
    assign last_c[0] = last_reg;

    for (genvar r = 1; r < Stages; r++) begin : g_round
        aesrk_round u_round (
            .aclk        (aclk),
            .en          (adv),
            .rcon        (RCON[r-1]),
            .final_round (r == Rounds),
            .state_in    (st_c[r-1]),
            .key_in      (key_c[r-1]),
            .last_in     (last_c[r-1]),
            .state_out   (st_c[r]),
            .key_out     (key_c[r]),
            .last_out    (last_c[r])
        );
    end

    // Shift valid bits with the data.
    always_comb begin
        vld_next = vld_reg;
        if (adv) begin
            vld_next = {vld_reg[Stages-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign m_valid       = vld_reg[Stages-1];
    assign m_cipher_high = st_c[Stages-1][127:64];
    assign m_cipher_low  = st_c[Stages-1][63:0];
    assign m_last_out    = last_c[Stages-1];

    // A stalled result must not move the chain.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(vld_reg))
        else $error("pipeline moved under output stall");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input refused with empty output stage");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted request lost at stage 0");

    a_count_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $countones(vld_reg) == $past($countones(vld_reg)))
        else $error("valid count changed while frozen");

endmodule
